// ===== hdl/fdl_pkg.sv =====
// Shared widths, register indexes, types and the round/saturate function of the delay line.
package fdl_pkg;

    localparam int DEPTH         = 4096;
    localparam int SAMPLE_BITS   = 24;
    localparam int FRACTION_BITS = 16;
    localparam int ADDR_BITS     = $clog2(DEPTH);
    localparam int LEN_BITS      = ADDR_BITS + 1;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;
    localparam int DIFF_BITS     = SAMPLE_BITS + 1;
    localparam int PROD_BITS     = DIFF_BITS + FRACTION_BITS + 1;
    localparam int ACC_BITS      = PROD_BITS + 1;
    localparam int ROUND_BITS    = ACC_BITS - FRACTION_BITS;

    localparam logic [CFG_INDEX_BITS-1:0] REG_BUFFER_LENGTH  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DELAY_WHOLE    = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DELAY_FRACTION = 2'd2;

    localparam logic [LEN_BITS-1:0] LEN_MIN = LEN_BITS'(2);
    localparam logic [LEN_BITS-1:0] LEN_MAX = LEN_BITS'(DEPTH);

    typedef logic signed [SAMPLE_BITS-1:0]   sample_t;
    typedef logic        [ADDR_BITS-1:0]     addr_t;
    typedef logic        [LEN_BITS-1:0]      len_t;
    typedef logic        [FRACTION_BITS-1:0] frac_t;
    typedef logic signed [ACC_BITS-1:0]      acc_t;

    // Round half up by dropping the fraction bits of acc plus one half,
    // then clamp to the sample range.
    function automatic sample_t round_sat(input acc_t acc);
        acc_t                          biased;
        logic signed [ROUND_BITS-1:0] y;
        logic signed [ROUND_BITS-1:0] smax;
        logic signed [ROUND_BITS-1:0] smin;
        biased = acc + (ACC_BITS'(1) <<< (FRACTION_BITS - 1));
        y      = ROUND_BITS'(biased >>> FRACTION_BITS);
        smax   = ROUND_BITS'((1 <<< (SAMPLE_BITS - 1)) - 1);
        smin   = -smax - ROUND_BITS'(1);
        if (y > smax) begin
            return SAMPLE_BITS'(smax);
        end
        else if (y < smin) begin
            return SAMPLE_BITS'(smin);
        end
        return SAMPLE_BITS'(y);
    endfunction

endpackage

// ===== hdl/fdl_ram.sv =====
// Generic RAM: one write port, two read ports with registered read data.
module fdl_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

// ===== hdl/fdl_interp.sv =====
// Interpolation datapath: weighted difference, then round, saturate and output register.
module fdl_interp (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  fdl_pkg::sample_t       x0,
    input  fdl_pkg::sample_t       x1,
    input  fdl_pkg::frac_t         frac,
    output logic                   out_valid,
    input  logic                   out_ready,
    output fdl_pkg::sample_t       out_sample
);

    logic                                       prod_valid_reg;
    logic signed [fdl_pkg::PROD_BITS-1:0]       prod_reg;
    fdl_pkg::sample_t                           base_reg;
    logic                                       out_valid_reg;
    fdl_pkg::sample_t                           out_reg;

    logic                                       out_en;
    logic                                       prod_en;
    logic signed [fdl_pkg::DIFF_BITS-1:0]       diff;
    logic signed [fdl_pkg::FRACTION_BITS:0]     frac_s;
    logic signed [fdl_pkg::PROD_BITS-1:0]       prod_next;
    fdl_pkg::acc_t                              acc;

    assign out_en   = !out_valid_reg || out_ready;
    assign prod_en  = !prod_valid_reg || out_en;
    assign in_ready = prod_en;

    // x0*(1-f) + x1*f is computed as x0*1 + (x1-x0)*f with one multiplier.
    assign diff      = fdl_pkg::DIFF_BITS'(x1) - fdl_pkg::DIFF_BITS'(x0);
    assign frac_s    = $signed({1'b0, frac});
    assign prod_next = fdl_pkg::PROD_BITS'(diff * frac_s);
    assign acc       = (fdl_pkg::ACC_BITS'(base_reg) <<< fdl_pkg::FRACTION_BITS)
                     + fdl_pkg::ACC_BITS'(prod_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (prod_en)
            begin
                prod_valid_reg <= in_valid;
            end
            if (out_en)
            begin
                out_valid_reg <= prod_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (prod_en && in_valid)
        begin
            prod_reg <= prod_next;
            base_reg <= x0;
        end
        if (out_en && prod_valid_reg)
        begin
            out_reg <= fdl_pkg::round_sat(acc);
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_sample = out_reg;

endmodule

// ===== hdl/fractional_delay_line.sv =====
// Top level of the linear-interpolated fractional delay line.
//
// Usage: one signed 24-bit sample enters per s_axis transaction and one
// interpolated sample leaves per m_axis transaction, in order. The output
// lies delay_whole + delay_fraction/65536 samples behind the sample just
// written, with both neighbors read from the circular sample store.
// Throughput is one sample per clock while m_axis_tready does not hold the
// pipeline: each accepted sample costs one write and two reads of the
// dual-read sample RAM, all issued in the accept cycle. From s_axis
// acceptance to m_axis tvalid a sample passes the RAM read register, then
// the multiply register, then the round and output register.
// A register is written whenever cfg_write is high. The user must keep the
// port used only while no samples are in flight; this is not enforced.
// buffer_length writes and reset empty the store and restart the write index.
// The store is not swept at reset: entries not yet written since the last
// clear read as zero, tracked by the write index and a wrapped flag, so the
// block accepts samples from the first cycle after reset.
// When m_axis_tready is low the pipeline fills and s_axis_tready drops once
// all three stages hold a sample; nothing is lost.
module fractional_delay_line (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [23:0]                           s_axis_tdata,  // [23:0] sample_in
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [23:0]                           m_axis_tdata,  // [23:0] sample_out
    input  logic                                  cfg_write,
    input  logic [fdl_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [fdl_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

    fdl_pkg::len_t      len_reg;
    fdl_pkg::addr_t     whole_reg;
    fdl_pkg::frac_t     frac_reg;
    fdl_pkg::addr_t     wr_index_reg;
    logic               wrapped_reg;

    logic               v1_reg;
    logic               byp0_reg;
    logic               byp1_reg;
    logic               ok0_reg;
    logic               ok1_reg;
    fdl_pkg::sample_t   new_reg;
    fdl_pkg::frac_t     f1_reg;

    logic               accept;
    logic               s2_ready;
    fdl_pkg::len_t      cfg_len;
    fdl_pkg::len_t      len_eff;
    fdl_pkg::addr_t     dw;
    fdl_pkg::addr_t     p0;
    fdl_pkg::addr_t     p1;
    fdl_pkg::addr_t     last_index;
    fdl_pkg::len_t      wrap_sum;
    fdl_pkg::sample_t   sample_in;
    logic [23:0]        rd_a;
    logic [23:0]        rd_b;
    fdl_pkg::sample_t   x0;
    fdl_pkg::sample_t   x1;
    fdl_pkg::sample_t   sample_out;

    assign sample_in     = fdl_pkg::sample_t'(s_axis_tdata);
    assign s_axis_tready = !v1_reg || s2_ready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // A written buffer length is clamped into the usable range right away.
    always_comb
    begin
        cfg_len = fdl_pkg::LEN_BITS'(cfg_data);
        if (cfg_len < fdl_pkg::LEN_MIN)
        begin
            len_eff = fdl_pkg::LEN_MIN;
        end
        else if (cfg_len > fdl_pkg::LEN_MAX)
        begin
            len_eff = fdl_pkg::LEN_MAX;
        end
        else
        begin
            len_eff = cfg_len;
        end
    end

    // Read positions: p0 = w - dw, p1 = p0 - 1, both modulo the length.
    always_comb
    begin
        last_index = fdl_pkg::ADDR_BITS'(len_reg - fdl_pkg::LEN_BITS'(1));
        if ({1'b0, whole_reg} >= len_reg)
        begin
            dw = last_index;
        end
        else
        begin
            dw = whole_reg;
        end
        wrap_sum = {1'b0, wr_index_reg} + len_reg - {1'b0, dw};
        if (wr_index_reg >= dw)
        begin
            p0 = wr_index_reg - dw;
        end
        else
        begin
            p0 = fdl_pkg::ADDR_BITS'(wrap_sum);
        end
        if (p0 == '0)
        begin
            p1 = last_index;
        end
        else
        begin
            p1 = p0 - fdl_pkg::ADDR_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg      <= fdl_pkg::LEN_MAX;
            whole_reg    <= fdl_pkg::ADDR_BITS'(1);
            frac_reg     <= '0;
            wr_index_reg <= '0;
            wrapped_reg  <= 1'b0;
            v1_reg       <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                v1_reg <= accept;
            end
            if (cfg_write)
            begin
                case (cfg_index)
                    fdl_pkg::REG_BUFFER_LENGTH:
                    begin
                        len_reg      <= len_eff;
                        wr_index_reg <= '0;
                        wrapped_reg  <= 1'b0;
                    end
                    fdl_pkg::REG_DELAY_WHOLE:
                    begin
                        whole_reg <= fdl_pkg::ADDR_BITS'(cfg_data);
                    end
                    fdl_pkg::REG_DELAY_FRACTION:
                    begin
                        frac_reg <= cfg_data;
                    end
                    default:
                    begin
                    end
                endcase
            end
            else if (accept)
            begin
                if (wr_index_reg == last_index)
                begin
                    wr_index_reg <= '0;
                    wrapped_reg  <= 1'b1;
                end
                else
                begin
                    wr_index_reg <= wr_index_reg + fdl_pkg::ADDR_BITS'(1);
                end
            end
        end
    end

    // Side information that travels with the RAM read. Until the store has
    // wrapped once, only entries up to the write index hold written samples.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byp0_reg <= (p0 == wr_index_reg);
            byp1_reg <= (p1 == wr_index_reg);
            ok0_reg  <= wrapped_reg || (p0 <= wr_index_reg);
            ok1_reg  <= wrapped_reg || (p1 <= wr_index_reg);
            new_reg  <= sample_in;
            f1_reg   <= frac_reg;
        end
    end

    fdl_ram #(
        .WIDTH (fdl_pkg::SAMPLE_BITS),
        .DEPTH (fdl_pkg::DEPTH)
    ) u_store (
        .clk     (clk),
        .we      (accept),
        .waddr   (wr_index_reg),
        .wdata   (s_axis_tdata),
        .re      (accept),
        .raddr_a (p0),
        .raddr_b (p1),
        .rdata_a (rd_a),
        .rdata_b (rd_b)
    );

    // The sample written in the same cycle is forwarded, since the RAM
    // returns the old contents on a read of the address being written.
    always_comb
    begin
        if (byp0_reg)
        begin
            x0 = new_reg;
        end
        else if (ok0_reg)
        begin
            x0 = fdl_pkg::sample_t'(rd_a);
        end
        else
        begin
            x0 = '0;
        end
        if (byp1_reg)
        begin
            x1 = new_reg;
        end
        else if (ok1_reg)
        begin
            x1 = fdl_pkg::sample_t'(rd_b);
        end
        else
        begin
            x1 = '0;
        end
    end

    fdl_interp u_interp (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (v1_reg),
        .in_ready   (s2_ready),
        .x0         (x0),
        .x1         (x1),
        .frac       (f1_reg),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_sample (sample_out)
    );

    assign m_axis_tdata = sample_out;

    a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, wr_index_reg} < len_reg)
        else $error("write index is outside the buffer length");

    a_length_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (len_reg >= fdl_pkg::LEN_MIN) && (len_reg <= fdl_pkg::LEN_MAX))
        else $error("effective buffer length is out of range");

    a_clear_on_length: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_write && (cfg_index == fdl_pkg::REG_BUFFER_LENGTH))
        |=> (wr_index_reg == '0) && !wrapped_reg)
        else $error("buffer length write did not empty the store");

    a_fill_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !cfg_write && !wrapped_reg && (wr_index_reg != last_index))
        |=> (wr_index_reg == $past(wr_index_reg) + fdl_pkg::ADDR_BITS'(1)) && !wrapped_reg)
        else $error("write index did not advance by one while filling");

endmodule

// ===== tb/tb_fractional_delay_line.sv =====
// Self-checking testbench of the fractional delay line with a bit-accurate delay predictor.
module tb_fractional_delay_line;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [fdl_pkg::CFG_INDEX_BITS-1:0] REG_UNMAPPED = 2'd3;
    localparam int       HOLD_CYCLES  = 300;
    localparam int       SETTLE_CYCLES = 8;
    localparam int       PHASE_ITEMS  = 104;
    localparam longint   UNITY        = longint'(1) << fdl_pkg::FRACTION_BITS;
    localparam longint   SAMPLE_MAX   = (longint'(1) << (fdl_pkg::SAMPLE_BITS - 1)) - 1;
    localparam longint   SAMPLE_MIN   = -SAMPLE_MAX - 1;

    // Holds its own copy of the store and registers and predicts each output sample.
    class delay_predictor;
        fdl_pkg::sample_t store [fdl_pkg::DEPTH];
        int unsigned      wr_pos;
        int unsigned      length_reg;
        int unsigned      whole_reg;
        int unsigned      fraction_reg;
        fdl_pkg::sample_t expected_samples [$];
        int unsigned      failures;

        function new();
            foreach (store[i]) store[i] = '0;
            wr_pos       = 0;
            length_reg   = fdl_pkg::DEPTH;
            whole_reg    = 1;
            fraction_reg = 0;
            failures     = 0;
        endfunction

        function void write_register(logic [fdl_pkg::CFG_INDEX_BITS-1:0] idx,
                                     logic [fdl_pkg::CFG_DATA_BITS-1:0] data);
            case (idx)
                fdl_pkg::REG_BUFFER_LENGTH:
                begin
                    length_reg = data[fdl_pkg::LEN_BITS-1:0];
                    foreach (store[i]) store[i] = '0;
                    wr_pos = 0;
                end
                fdl_pkg::REG_DELAY_WHOLE:
                    whole_reg = data[fdl_pkg::ADDR_BITS-1:0];
                fdl_pkg::REG_DELAY_FRACTION:
                    fraction_reg = data[fdl_pkg::FRACTION_BITS-1:0];
                default:            ;
            endcase
        endfunction

        function void note_sample(fdl_pkg::sample_t x);
            int unsigned span;
            int unsigned w;
            int unsigned whole;
            int unsigned p0;
            int unsigned p1;
            longint      wt1;
            longint      acc;
            longint      y;
            span = (length_reg < 2) ? 2 :
                   ((length_reg > fdl_pkg::DEPTH) ? fdl_pkg::DEPTH : length_reg);
            w     = wr_pos % span;
            whole = (whole_reg >= span) ? span - 1 : whole_reg;
            store[w] = x;
            p0  = (w + span - whole) % span;
            p1  = (p0 + span - 1) % span;
            wt1 = fraction_reg;
            acc = longint'(store[p0]) * (UNITY - wt1) + longint'(store[p1]) * wt1;
            // Arithmetic shift floors, so adding one half first rounds ties upward.
            y = (acc + (UNITY >>> 1)) >>> fdl_pkg::FRACTION_BITS;
            if (y > SAMPLE_MAX) y = SAMPLE_MAX;
            if (y < SAMPLE_MIN) y = SAMPLE_MIN;
            expected_samples.push_back(fdl_pkg::sample_t'(y));
            wr_pos = (w + 1 == span) ? 0 : w + 1;
        endfunction

        function void check_sample(logic [fdl_pkg::SAMPLE_BITS-1:0] got);
            fdl_pkg::sample_t want;
            if (expected_samples.size() == 0)
            begin
                $error("sample_out: no result expected, actual %0d", $signed(got));
                failures++;
            end
            else
            begin
                want = expected_samples.pop_front();
                if (want !== got)
                begin
                    $error("sample_out: expected %0d, actual %0d", want, $signed(got));
                    failures++;
                end
            end
        endfunction

        function int pending();
            return expected_samples.size();
        endfunction
    endclass

    logic                               clk           = 1'b0;
    logic                               rst_n         = 1'b0;
    logic                               s_axis_tvalid = 1'b0;
    logic                               s_axis_tready;
    logic [fdl_pkg::SAMPLE_BITS-1:0]    s_axis_tdata  = '0;    // [23:0] sample_in
    logic                               m_axis_tvalid;
    logic                               m_axis_tready = 1'b0;
    logic [fdl_pkg::SAMPLE_BITS-1:0]    m_axis_tdata;          // [23:0] sample_out
    logic                               cfg_write     = 1'b0;
    logic [fdl_pkg::CFG_INDEX_BITS-1:0] cfg_index     = '0;
    logic [fdl_pkg::CFG_DATA_BITS-1:0]  cfg_data      = '0;

    delay_predictor predicted;
    int             send_idle_pct = 0;
    int             recv_idle_pct = 0;
    int             hold_requests = 0;

    fractional_delay_line dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #1 clk = ~clk;

    function automatic fdl_pkg::sample_t random_sample();
        case ($urandom_range(9))
            0:       return fdl_pkg::sample_t'(SAMPLE_MAX);
            1:       return fdl_pkg::sample_t'(SAMPLE_MIN);
            default: return fdl_pkg::sample_t'($urandom);
        endcase
    endfunction

    task automatic push_sample(input fdl_pkg::sample_t x);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= x;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        predicted.note_sample(x);
    endtask

    task automatic push_list(input fdl_pkg::sample_t samples [$]);
        foreach (samples[i]) push_sample(samples[i]);
    endtask

    task automatic write_register(input logic [fdl_pkg::CFG_INDEX_BITS-1:0] idx,
                                  input logic [fdl_pkg::CFG_DATA_BITS-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        predicted.write_register(idx, data);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    // Stops offering samples and waits until every predicted sample has come out.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (predicted.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Output side: checks each transaction and decides tready for the next cycle.
    initial
    begin
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
            begin
                predicted.check_sample(m_axis_tdata);
            end
            if (hold_seen != hold_requests)
            begin
                hold_seen = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    initial
    begin
        #1_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        logic [fdl_pkg::CFG_DATA_BITS-1:0] len_word;
        logic [fdl_pkg::CFG_DATA_BITS-1:0] whole_word;
        logic [fdl_pkg::CFG_DATA_BITS-1:0] fraction_word;
        int unsigned                       span;

        predicted = new();
        span      = fdl_pkg::DEPTH;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: a one-sample delay passes the extremes straight through.
        push_list({fdl_pkg::sample_t'(SAMPLE_MAX), fdl_pkg::sample_t'(SAMPLE_MIN),
                   fdl_pkg::sample_t'(0), fdl_pkg::sample_t'(-1),
                   fdl_pkg::sample_t'(24'h555555), fdl_pkg::sample_t'(24'hAAAAAA)});
        wait_drained();

        // Zero delay returns the sample just written.
        write_register(fdl_pkg::REG_DELAY_WHOLE, '0);
        write_register(fdl_pkg::REG_DELAY_FRACTION, '0);
        push_list({fdl_pkg::sample_t'(SAMPLE_MAX), fdl_pkg::sample_t'(SAMPLE_MIN),
                   fdl_pkg::sample_t'(123)});
        wait_drained();

        // Length below the minimum acts as two; half-sample weights hit the rounding ties.
        write_register(fdl_pkg::REG_BUFFER_LENGTH, '0);
        write_register(fdl_pkg::REG_DELAY_WHOLE, 16'd1);
        write_register(fdl_pkg::REG_DELAY_FRACTION, 16'h8000);
        push_list({fdl_pkg::sample_t'(1), fdl_pkg::sample_t'(0), fdl_pkg::sample_t'(-1),
                   fdl_pkg::sample_t'(0), fdl_pkg::sample_t'(SAMPLE_MAX),
                   fdl_pkg::sample_t'(SAMPLE_MIN)});
        wait_drained();

        // Length of one, an oversized whole delay and the largest fraction.
        write_register(fdl_pkg::REG_BUFFER_LENGTH, 16'd1);
        write_register(fdl_pkg::REG_DELAY_WHOLE, 16'hFFFF);
        write_register(fdl_pkg::REG_DELAY_FRACTION, 16'hFFFF);
        push_list({fdl_pkg::sample_t'(SAMPLE_MAX), fdl_pkg::sample_t'(SAMPLE_MIN),
                   fdl_pkg::sample_t'(SAMPLE_MAX), fdl_pkg::sample_t'(SAMPLE_MIN)});
        wait_drained();

        // A write to an unmapped index must leave every register alone.
        write_register(REG_UNMAPPED, 16'hFFFF);
        push_list({fdl_pkg::sample_t'(7), fdl_pkg::sample_t'(-7),
                   fdl_pkg::sample_t'(SAMPLE_MAX)});
        wait_drained();
        span = 2;

        for (int mode = 0; mode < 3; mode++)
        begin
            send_idle_pct = (mode == 0) ? 36 : ((mode == 1) ? 86 : 0);
            recv_idle_pct = (mode == 0) ? 86 : ((mode == 1) ? 36 : 0);
            for (int phase = 0; phase < 4; phase++)
            begin
                // Sometimes keep the store contents across a change of delay.
                if ($urandom_range(3) != 0)
                begin
                    case ($urandom_range(7))
                        0:       len_word = '0;
                        1:       len_word = 16'd1;
                        2:       len_word = 16'd2;
                        3:       len_word = 16'(fdl_pkg::DEPTH);
                        4:       len_word = 16'hFFFF;
                        5:       len_word = 16'($urandom_range(fdl_pkg::DEPTH));
                        default: len_word = 16'($urandom_range(40, 3));
                    endcase
                    write_register(fdl_pkg::REG_BUFFER_LENGTH, len_word);
                    span = len_word[fdl_pkg::LEN_BITS-1:0];
                    if (span < 2) span = 2;
                    if (span > fdl_pkg::DEPTH) span = fdl_pkg::DEPTH;
                end
                case ($urandom_range(5))
                    0:       whole_word = '0;
                    1:       whole_word = 16'(span - 1);
                    2:       whole_word = 16'hFFFF;
                    3:       whole_word = 16'($urandom_range(fdl_pkg::DEPTH - 1));
                    default: whole_word = 16'($urandom_range(span - 1));
                endcase
                write_register(fdl_pkg::REG_DELAY_WHOLE, whole_word);
                case ($urandom_range(4))
                    0:       fraction_word = '0;
                    1:       fraction_word = 16'hFFFF;
                    2:       fraction_word = 16'h8000;
                    default: fraction_word = 16'($urandom);
                endcase
                write_register(fdl_pkg::REG_DELAY_FRACTION, fraction_word);
                if (mode == 2 && phase == 0) hold_requests++;
                repeat (PHASE_ITEMS) push_sample(random_sample());
                wait_drained();
            end
        end

        if (predicted.failures == 0 && predicted.pending() == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
